[sv/tea_pkg.sv]
`timescale 1ns / 1ps
// Package for the TEA block cipher core: cipher constants, codes and the round mixing function.
// Used by tea_block_cipher_core; it depends on nothing else.
package tea_pkg;

  // Round constant, decryption start sum and the number of TEA iterations in each block.
  localparam logic [31:0] TEA_DELTA   = 32'h9e37_79b9;
  localparam logic [31:0] TEA_DEC_SUM = 32'hC6EF_3720;
  localparam int          NUM_CYCLES  = 32;

  // Each cycle has two half rounds, and each half round is one pipeline stage.
  localparam int NUM_STAGES = 2 * NUM_CYCLES;

  // Register map of the configuration port.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Operation carried with each item.
  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } tea_cmd_e;

  // Word index of a key register, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_KEY_WORD0 = 2'd0,
    REG_KEY_WORD1 = 2'd1,
    REG_KEY_WORD2 = 2'd2,
    REG_KEY_WORD3 = 2'd3
  } tea_reg_e;

  // Round sum used by encryption in cycle cyc (counted from zero).
  function automatic logic [31:0] enc_sum(input int cyc);
    logic [63:0] prod;
    prod = 64'(TEA_DELTA) * 64'(cyc + 1);
    return prod[31:0];
  endfunction

  // Round sum used by decryption in cycle cyc (counted from zero).
  function automatic logic [31:0] dec_sum(input int cyc);
    logic [63:0] prod;
    prod = 64'(TEA_DELTA) * 64'(NUM_CYCLES - cyc);
    return prod[31:0];
  endfunction

  // TEA mixing term of one half round, all sums modulo 2^32.
  function automatic logic [31:0] mix_word(input logic [31:0] w, input logic [31:0] sum,
                                           input logic [31:0] kl, input logic [31:0] kr);
    return ((w << 4) + kl) ^ (w + sum) ^ ((w >> 5) + kr);
  endfunction

endpackage

[sv/tea_block_cipher_core.sv]
`timescale 1ns / 1ps
// Top level of the TEA block cipher core: key registers on an APB-style port and the round pipeline.
// Depends on tea_pkg for constants, codes and the mixing function.

// The core encrypts or decrypts one 64-bit block per item with 32 TEA iterations in ECB mode under
// the 128-bit key held in the four key registers (byte addresses 0, 4, 8 and 12). Every TEA
// half round is one register stage, so the pipeline is 64 stages deep: while results are taken,
// a block enters each cycle and leaves the last stage, a sustained rate of one block per clock.
// When the output item is not taken, the whole pipeline holds and in_ready_o drops in the same
// cycle, so nothing is lost or repeated. Keys must only be written while no block is in flight.
module tea_block_cipher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Block input channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [31:0] data_low_i,
  input  logic [31:0] data_high_i,
  // Block output channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_low_o,
  output logic [31:0] result_high_o,
  // Configuration port.
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tea_pkg::ADDR_W-1:0] paddr,
  input  logic [tea_pkg::DATA_W-1:0] pwdata,
  output logic [tea_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int Stages = tea_pkg::NUM_STAGES;

  // Key registers.
  logic [31:0]      key_q [4];
  tea_pkg::tea_reg_e reg_sel;
  logic             cfg_write;

  // Pipeline registers and their next values.
  logic              valid_q [Stages];
  tea_pkg::tea_cmd_e cmd_q   [Stages];
  logic [31:0]       y_q     [Stages];
  logic [31:0]       z_q     [Stages];
  logic [31:0]       y_d     [Stages];
  logic [31:0]       z_d     [Stages];
  logic              advance;

  // Register decode and write.
  assign pready    = 1'b1;
  assign reg_sel   = tea_pkg::tea_reg_e'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        key_q[i] <= '0;
      end
    end else if (cfg_write) begin
      unique case (reg_sel)
        tea_pkg::REG_KEY_WORD0: key_q[0] <= pwdata;
        tea_pkg::REG_KEY_WORD1: key_q[1] <= pwdata;
        tea_pkg::REG_KEY_WORD2: key_q[2] <= pwdata;
        tea_pkg::REG_KEY_WORD3: key_q[3] <= pwdata;
        default:                key_q[0] <= key_q[0];
      endcase
    end
  end

  // Register read.
  always_comb begin
    unique case (reg_sel)
      tea_pkg::REG_KEY_WORD0: prdata = key_q[0];
      tea_pkg::REG_KEY_WORD1: prdata = key_q[1];
      tea_pkg::REG_KEY_WORD2: prdata = key_q[2];
      tea_pkg::REG_KEY_WORD3: prdata = key_q[3];
      default:                prdata = '0;
    endcase
  end

  // The pipeline moves as a whole unless the last stage holds an item that is not taken.
  assign advance    = !valid_q[Stages-1] || out_ready_i;
  assign in_ready_o = advance;

  // One half round per stage.
  for (genvar k = 0; k < Stages; k++) begin : g_stage
    localparam int CycleIdx = k / 2;
    localparam logic FirstHalf = (k % 2) == 0;
    localparam logic [31:0] EncSum = tea_pkg::enc_sum(CycleIdx);
    localparam logic [31:0] DecSum = tea_pkg::dec_sum(CycleIdx);

    tea_pkg::tea_cmd_e cmd_in;
    logic [31:0]       y_in;
    logic [31:0]       z_in;
    logic              upd_y;
    logic [31:0]       src;
    logic [31:0]       dst;
    logic [31:0]       sum;
    logic [31:0]       kl;
    logic [31:0]       kr;
    logic [31:0]       mix;
    logic [31:0]       dst_new;

    // Stage inputs come from the ports or from the stage before.
    if (k == 0) begin : g_src_port
      assign cmd_in = tea_pkg::tea_cmd_e'(cmd_i);
      assign y_in   = data_low_i;
      assign z_in   = data_high_i;
    end else begin : g_src_stage
      assign cmd_in = cmd_q[k-1];
      assign y_in   = y_q[k-1];
      assign z_in   = z_q[k-1];
    end

    // Encryption updates y then z in each cycle; decryption updates z then y.
    always_comb begin
      unique case (cmd_in)
        tea_pkg::CMD_ENCRYPT: begin
          upd_y = FirstHalf;
          sum   = EncSum;
        end
        tea_pkg::CMD_DECRYPT: begin
          upd_y = !FirstHalf;
          sum   = DecSum;
        end
        default: begin
          upd_y = FirstHalf;
          sum   = EncSum;
        end
      endcase
      src     = upd_y ? z_in : y_in;
      dst     = upd_y ? y_in : z_in;
      kl      = upd_y ? key_q[0] : key_q[2];
      kr      = upd_y ? key_q[1] : key_q[3];
      mix     = tea_pkg::mix_word(src, sum, kl, kr);
      dst_new = (cmd_in == tea_pkg::CMD_ENCRYPT) ? dst + mix : dst - mix;
      y_d[k]  = upd_y ? dst_new : y_in;
      z_d[k]  = upd_y ? z_in : dst_new;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Stages; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else if (advance) begin
      valid_q[0] <= in_valid_i;
      for (int i = 1; i < Stages; i++) begin
        valid_q[i] <= valid_q[i-1];
      end
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      cmd_q[0] <= tea_pkg::tea_cmd_e'(cmd_i);
      for (int i = 1; i < Stages; i++) begin
        cmd_q[i] <= cmd_q[i-1];
      end
      for (int i = 0; i < Stages; i++) begin
        y_q[i] <= y_d[i];
        z_q[i] <= z_d[i];
      end
    end
  end

  // The last stage is the output register.
  assign out_valid_o   = valid_q[Stages-1];
  assign result_low_o  = y_q[Stages-1];
  assign result_high_o = z_q[Stages-1];

endmodule

[sv/tea_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the TEA block cipher core, bound to the top level.
// Depends on tea_block_cipher_core; it sees only the top-level ports.
module tea_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] result_low_o,
  input logic [31:0] result_high_o,
  input logic        pready
);

  // No result is shown while reset is applied.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("out_valid_o high during reset");

  // The input side is held exactly when a finished result waits.
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("in_ready_o does not follow output backpressure");

  // A stalled result stays and keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_low_o)
      && $stable(result_high_o))
    else $error("stalled result changed or dropped");

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind tea_block_cipher_core tea_checker u_tea_checker (.*);
